// File: sv/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types, round constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package s256_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0]  t_byte;

    // Byte position where the 64-bit length field starts in the last block
    localparam logic [5:0]  LENGTH_POS   = 6'd56;
    localparam logic [5:0]  LAST_POS     = 6'd63;
    localparam logic [5:0]  LAST_ROUND   = 6'd63;
    localparam logic [2:0]  LAST_WORD    = 3'd7;
    localparam t_byte       PAD_BYTE     = 8'h80;
    localparam logic [63:0] BITS_PER_BLK = 64'd512;

    // Initial hash value
    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants
    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Compression sigma: rotr 2, 13, 22
    function automatic t_word big_sig0(t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Compression sigma: rotr 6, 11, 25
    function automatic t_word big_sig1(t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Schedule sigma: rotr 7, rotr 18, shr 3
    function automatic t_word sml_sig0(t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Schedule sigma: rotr 17, rotr 19, shr 10
    function automatic t_word sml_sig1(t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// File: sv/s256_stream_if.sv
// ----------------------------------------------------------------------------
// s256 stream interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------

// Message byte channel
interface s256_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

// Digest word channel
interface s256_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    modport source (output valid, digest_word, word_index, digest_last, input ready);
    modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

// File: sv/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream; emits the eight digest words per message.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the hasher is idle into a 64-byte shift
// line that doubles as the message schedule window. The 64th byte of a block
// starts the compression: one shared round unit runs 64 rounds, one per cycle,
// then an update step adds the working variables into the hash; a full block
// holds off new requests until this is done. An end-of-message request shifts
// in the pad byte, zero fill and length one byte per clock outside the one or
// two compressions it triggers, then presents the digest words 0..7 on the
// output, one per request, with digest_last on word 7. After word 7 is taken
// the hasher is back at its initial state and ready for the next message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import s256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    s256_msg_if.sink    i_msg,
    s256_dig_if.source  o_dig
);

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ROUND  = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_PAD    = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    t_word       r_h [8];             // hash words
    t_word       n_h [8];
    t_word       r_v [8];             // working variables a..h
    t_word       n_v [8];
    t_word       r_w [16];            // block bytes / schedule window
    t_word       n_w [16];
    logic [5:0]  r_fill, n_fill;      // bytes held in the current block
    logic [63:0] r_bits, n_bits;      // bit count, then length shift-out
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_idx, n_idx;
    logic        r_finish, n_finish;  // message end pending
    logic        r_pad_sent, n_pad_sent;
    logic        r_len_ok, n_len_ok;  // length may go into this block
    logic        r_final, n_final;    // compression in flight is the last one

    logic        msg_acc;
    logic        dig_acc;
    logic        shift_byte;
    t_byte       shift_val;
    t_word       t1;
    t_word       t2;
    t_word       w_next;
    t_word       ch;
    t_word       maj;

    assign msg_acc = i_msg.valid && i_msg.ready;
    assign dig_acc = o_dig.valid && o_dig.ready;

    // Handshake and output payload
    assign i_msg.ready       = (r_state == ST_IDLE);
    assign o_dig.valid       = (r_state == ST_EMIT);
    assign o_dig.digest_word = r_h[0];
    assign o_dig.word_index  = r_idx;
    assign o_dig.digest_last = (r_idx == LAST_WORD);

    // Round unit
    always_comb begin
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + big_sig1(r_v[4]) + ch + K_ROUND[r_rnd] + r_w[0];
        t2     = big_sig0(r_v[0]) + maj;
        w_next = sml_sig1(r_w[14]) + r_w[9] + sml_sig0(r_w[1]) + r_w[0];
    end

    // Sequencer and datapath next state
    always_comb begin
        n_state    = r_state;
        n_h        = r_h;
        n_v        = r_v;
        n_w        = r_w;
        n_fill     = r_fill;
        n_bits     = r_bits;
        n_rnd      = r_rnd;
        n_idx      = r_idx;
        n_finish   = r_finish;
        n_pad_sent = r_pad_sent;
        n_len_ok   = r_len_ok;
        n_final    = r_final;
        shift_byte = 1'b0;
        shift_val  = i_msg.data_byte;

        case (r_state)
            ST_IDLE: begin
                if (msg_acc) begin
                    n_finish   = i_msg.end_of_message;
                    n_pad_sent = 1'b0;
                    n_final    = 1'b0;
                    if (i_msg.byte_present) begin
                        shift_byte = 1'b1;
                        n_fill     = r_fill + 6'd1;
                        if (r_fill == LAST_POS) begin
                            // block full: count it and compress
                            n_bits  = r_bits + BITS_PER_BLK;
                            n_v     = r_h;
                            n_rnd   = '0;
                            n_state = ST_ROUND;
                        end else if (i_msg.end_of_message) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_msg.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end

            ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[15] = w_next;
                n_rnd   = r_rnd + 6'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                if (r_final) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else if (r_finish) begin
                    // extra block after a pad that landed past the length field
                    if (r_pad_sent) begin
                        n_len_ok = 1'b1;
                    end
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end

            ST_PAD: begin
                shift_byte = 1'b1;
                if (!r_pad_sent) begin
                    shift_val  = PAD_BYTE;
                    n_pad_sent = 1'b1;
                    n_len_ok   = (r_fill < LENGTH_POS);
                    n_bits     = r_bits + {55'd0, r_fill, 3'b000};
                end else if (r_len_ok && (r_fill >= LENGTH_POS)) begin
                    // length, most significant byte first
                    shift_val = r_bits[63:56];
                    n_bits    = {r_bits[55:0], 8'h00};
                end else begin
                    shift_val = '0;
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == LAST_POS) begin
                    n_final = r_pad_sent && r_len_ok;
                    n_v     = r_h;
                    n_rnd   = '0;
                    n_state = ST_ROUND;
                end
            end

            ST_EMIT: begin
                if (dig_acc) begin
                    // rotate words out, refill with the initial hash
                    for (int i = 0; i < 7; i++) begin
                        n_h[i] = r_h[i + 1];
                    end
                    n_h[7] = H_INIT[r_idx];
                    n_idx  = r_idx + 3'd1;
                    if (r_idx == LAST_WORD) begin
                        n_fill     = '0;
                        n_bits     = '0;
                        n_finish   = 1'b0;
                        n_pad_sent = 1'b0;
                        n_len_ok   = 1'b0;
                        n_final    = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Byte shift through the block line
        if (shift_byte) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = {r_w[i][23:0], r_w[i + 1][31:24]};
            end
            n_w[15] = {r_w[15][23:0], shift_val};
        end
    end

    // Control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_h        <= H_INIT;
            r_fill     <= '0;
            r_bits     <= '0;
            r_rnd      <= '0;
            r_idx      <= '0;
            r_finish   <= 1'b0;
            r_pad_sent <= 1'b0;
            r_len_ok   <= 1'b0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_h        <= n_h;
            r_fill     <= n_fill;
            r_bits     <= n_bits;
            r_rnd      <= n_rnd;
            r_idx      <= n_idx;
            r_finish   <= n_finish;
            r_pad_sent <= n_pad_sent;
            r_len_ok   <= n_len_ok;
            r_final    <= n_final;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_w <= n_w;
    end

`ifndef ASSERT_OFF
    // Digest words go out in order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dig_acc && !o_dig.digest_last) |=>
            (o_dig.valid && (o_dig.word_index == $past(o_dig.word_index) + 3'd1)))
        else $error("digest word index did not advance");

    // After the last word the hasher is back at a fresh message
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dig_acc && o_dig.digest_last) |=>
            (i_msg.ready && (r_fill == 6'd0) && (r_bits == 64'd0) && (r_h[0] == H_INIT[0])))
        else $error("hasher not reinitialized after digest");

    // The last round is always followed by the hash update
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ROUND) && (r_rnd == LAST_ROUND)) |=> (r_state == ST_UPDATE))
        else $error("compression did not end after round 63");

    // Digest is only shown after a final compression
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_dig.valid) |-> ($past(r_state == ST_UPDATE) && $past(r_final)))
        else $error("digest shown without final block");
`endif

endmodule
